/* rtl/irrpump_pkg.sv */
`default_nettype none

package irrpump_pkg;

	localparam int MOIST_W = 7;
	localparam int CFG_W = 16;
	localparam int TIME_BITS_DEF = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [MOIST_W-1:0] MIN_MOIST_RST = 7'd30;
	localparam logic [MOIST_W-1:0] MAX_MOIST_RST = 7'd70;
	localparam logic [CFG_W-1:0] CHECK_INT_RST = 16'd10;
	localparam logic [CFG_W-1:0] MAX_WATER_RST = 16'd60;
	localparam logic [CFG_W-1:0] MANUAL_DUR_RST = 16'd30;
	localparam logic [CFG_W-1:0] LOCKOUT_RST = 16'd300;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_MOISTURE    = 3'd0,
		REG_MAX_MOISTURE    = 3'd1,
		REG_CHECK_INTERVAL  = 3'd2,
		REG_MAX_WATER_TIME  = 3'd3,
		REG_MANUAL_DURATION = 3'd4,
		REG_LOCKOUT_TIME    = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OFF_NONE      = 2'd0,
		OFF_MOIST_MAX = 2'd1,
		OFF_MAX_TIME  = 2'd2,
		OFF_MANUAL    = 2'd3
	} off_cause_t;

	typedef struct packed {
		logic [MOIST_W-1:0] moisture;
		logic               manual_mode;
		logic               manual_start;
	} tick_t;

	typedef struct packed {
		logic       pump_on;
		logic       turned_on;
		off_cause_t off_cause;
		logic       sensor_checked;
	} result_t;

endpackage

`default_nettype wire

/* rtl/irrigation_pump_hysteresis_control.sv */
// channel   | handshake                      | payload
// tick      | tick_valid / tick_stall        | tick (moisture, manual_mode, manual_start)
// result    | result_valid / result_stall    | result (pump_on, turned_on, off_cause, ...)
// config    | wr_en (no wait)                | wr_index, wr_data
//
// one item per cycle sustained while the result is not stalled; the accepting edge loads the
// input register, and the state update and the result register load follow as the item moves on.
// arst_n clears the pump state and the valids, and sets the second counters and the config registers to defaults.
// a stalled result holds; tick_stall is high only while the input register holds an
// item and the result register holds a stalled one.
`default_nettype none

module irrigation_pump_hysteresis_control
	import irrpump_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  tick_valid,
	output logic                 tick_stall,
	input  tick_t                tick,
	output logic                 result_valid,
	input  wire                  result_stall,
	output result_t              result,
	input  wire                  wr_en,
	input  wire  [CFG_IDX_W-1:0] wr_index,
	input  wire  [CFG_W-1:0]     wr_data
);

	localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	logic [MOIST_W-1:0] min_moist_q, max_moist_q;
	logic [CFG_W-1:0]   check_int_q, max_water_q, manual_dur_q, lockout_q;

	logic                 pump_q, mact_q;
	logic [TIME_BITS-1:0] since_check_q, since_wend_q, since_pact_q, since_mstart_q;

	logic  valid_s1;
	tick_t tick_s1;

	logic    move_s1;
	logic    pump_d, mact_d;
	logic [TIME_BITS-1:0] sc_d, swe_d, spa_d, sms_d;
	result_t res_d;

	function automatic logic [TIME_BITS-1:0] tick_up(input logic [TIME_BITS-1:0] c);
		return (c == TIME_MAX) ? TIME_MAX : c + 1'b1;
	endfunction

	function automatic logic reached(input logic [TIME_BITS-1:0] c,
	                                 input logic [CFG_W-1:0] thr);
		return (CMP_W'(c) >= CMP_W'(thr)) || (c == TIME_MAX);
	endfunction

	assign move_s1 = valid_s1 && (!result_valid || !result_stall);
	assign tick_stall = valid_s1 && !move_s1;

	always_comb begin
		logic was_on, turn_on, off_now;
		sc_d = tick_up(since_check_q);
		swe_d = tick_up(since_wend_q);
		spa_d = tick_up(since_pact_q);
		sms_d = tick_up(since_mstart_q);
		pump_d = pump_q;
		mact_d = mact_q;
		was_on = pump_q;
		turn_on = 1'b0;
		off_now = 1'b0;
		res_d = '0;
		res_d.off_cause = OFF_NONE;
		if (tick_s1.manual_mode) begin
			if (pump_q && mact_q && reached(sms_d, manual_dur_q)) begin
				pump_d = 1'b0;
				mact_d = 1'b0;
				spa_d = '0;
				res_d.off_cause = OFF_MANUAL;
			end
			if (tick_s1.manual_start) begin
				if (!pump_d) begin
					pump_d = 1'b1;
					spa_d = '0;
					res_d.turned_on = 1'b1;
				end
				mact_d = 1'b1;
				sms_d = '0;
			end
		end else if (reached(sc_d, check_int_q)) begin
			sc_d = '0;
			res_d.sensor_checked = 1'b1;
			turn_on = (tick_s1.moisture < min_moist_q) && reached(swe_d, lockout_q)
			          && !pump_q;
			if (turn_on) begin
				pump_d = 1'b1;
				spa_d = '0;
				res_d.turned_on = 1'b1;
			end
			if (pump_d) begin
				if (tick_s1.moisture >= max_moist_q) begin
					off_now = 1'b1;
					res_d.off_cause = OFF_MOIST_MAX;
				end else if (reached(spa_d, max_water_q)) begin
					off_now = 1'b1;
					res_d.off_cause = OFF_MAX_TIME;
				end
			end
			if (off_now) begin
				pump_d = 1'b0;
				mact_d = 1'b0;
				spa_d = '0;
			end
			if (was_on && !pump_d) begin
				swe_d = '0;
			end
		end
		res_d.pump_on = pump_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_moist_q <= MIN_MOIST_RST;
			max_moist_q <= MAX_MOIST_RST;
			check_int_q <= CHECK_INT_RST;
			max_water_q <= MAX_WATER_RST;
			manual_dur_q <= MANUAL_DUR_RST;
			lockout_q <= LOCKOUT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MIN_MOISTURE:    min_moist_q <= wr_data[MOIST_W-1:0];
				REG_MAX_MOISTURE:    max_moist_q <= wr_data[MOIST_W-1:0];
				REG_CHECK_INTERVAL:  check_int_q <= wr_data;
				REG_MAX_WATER_TIME:  max_water_q <= wr_data;
				REG_MANUAL_DURATION: manual_dur_q <= wr_data;
				REG_LOCKOUT_TIME:    lockout_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!tick_stall) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!tick_stall && tick_valid) begin
			tick_s1 <= tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_q <= 1'b0;
			mact_q <= 1'b0;
			since_check_q <= TIME_MAX;
			since_wend_q <= TIME_MAX;
			since_pact_q <= TIME_MAX;
			since_mstart_q <= '0;
			result_valid <= 1'b0;
		end else begin
			if (move_s1) begin
				pump_q <= pump_d;
				mact_q <= mact_d;
				since_check_q <= sc_d;
				since_wend_q <= swe_d;
				since_pact_q <= spa_d;
				since_mstart_q <= sms_d;
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			result <= res_d;
		end
	end

	a_off_means_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.sensor_checked && (result.off_cause != OFF_NONE)
		|-> !result.pump_on)
		else $error("pump reported on after an auto switch-off");

	a_on_reported: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.turned_on && (result.off_cause == OFF_NONE)
		|-> result.pump_on)
		else $error("switch-on reported but pump off");

	a_check_not_manual: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.sensor_checked |-> (result.off_cause != OFF_MANUAL))
		else $error("manual switch-off during an auto evaluation");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 |=> result_valid && (result.pump_on == pump_q))
		else $error("result pump state differs from stored state");

	a_manual_needs_pump: assert property (@(posedge clk) disable iff (!arst_n)
		mact_q |-> pump_q)
		else $error("manual run active with pump off");

endmodule

`default_nettype wire
